// ===== sv/bounded_random_integer_defines.svh =====
// Assertion macros shared by the bounded random integer RTL.
`ifndef BOUNDED_RANDOM_INTEGER_DEFINES_SVH
`define BOUNDED_RANDOM_INTEGER_DEFINES_SVH

`ifndef SYNTHESIS
`define BRI_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bri: assertion failed");
`define BRI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bri: assertion failed");
`else
`define BRI_ASSERT_SAME(lbl, ante, cons)
`define BRI_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== sv/bri_pkg.sv =====
// Types, constants and the output permutation of the bounded random integer block.
package bri_pkg;

  localparam logic [63:0] LCG_MULT   = 64'h5851_F42D_4C95_7F2D;
  localparam logic [31:0] LCG_MULT_LO = LCG_MULT[31:0];
  localparam logic [31:0] LCG_MULT_HI = LCG_MULT[63:32];

  localparam logic [63:0] SEED_RST   = 64'h0000_0000_DEAD_BEEF;
  localparam logic [63:0] STREAM_RST = 64'h0000_0BAD_CAFE_FACE;

  localparam int unsigned ADDR_W = 4;
  localparam logic        REG_SEED   = 1'b0;
  localparam logic        REG_STREAM = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED,
    ST_P0,
    ST_P1,
    ST_P2,
    ST_P3,
    ST_ADV,
    ST_OUT
  } bri_state_t;

  typedef enum logic [1:0] {
    MUL_LL,
    MUL_HL,
    MUL_LH,
    MUL_SW
  } bri_mul_t;

  typedef struct packed {
    logic     seed;
    logic     start;
    logic     word_ld;
    logic     acc_ld;
    logic     acc_add;
    logic     adv;
    logic     eval;
    logic     out_ld;
    bri_mul_t mul_sel;
  } bri_cmd_t;

  typedef struct packed {
    logic done_now;
    logic out_free;
  } bri_status_t;

  function automatic logic [31:0] pcg_word(input logic [63:0] old);
    logic [63:0] mix;
    logic [31:0] xs;
    logic [4:0]  rot;
    mix = (old >> 18) ^ old;
    xs  = mix[58:27];
    rot = old[63:59];
    return (xs >> rot) | (xs << (5'd0 - rot));
  endfunction

endpackage

// ===== sv/bri_ctrl.sv =====
// Sequencer for seeding, word draws and result hand-off.
`include "bounded_random_integer_defines.svh"

module bri_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 cfg_wr,
  input  bri_pkg::bri_status_t status,
  output logic                 in_ready,
  output bri_pkg::bri_cmd_t    cmd
);
  import bri_pkg::*;

  bri_state_t state_r, state_nxt;
  logic       item_r, item_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_SEED;
      item_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      item_r  <= item_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    item_nxt  = item_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_P0;
          item_nxt  = 1'b1;
        end
      end
      ST_SEED: begin
        state_nxt = ST_P0;
        item_nxt  = 1'b0;
      end
      ST_P0: state_nxt = ST_P1;
      ST_P1: state_nxt = ST_P2;
      ST_P2: state_nxt = ST_P3;
      ST_P3: state_nxt = ST_ADV;
      ST_ADV: begin
        if (!item_r) begin
          state_nxt = ST_IDLE;
        end else if (status.done_now) begin
          state_nxt = ST_OUT;
        end else begin
          state_nxt = ST_P0;
        end
      end
      ST_OUT: begin
        if (status.out_free) begin
          state_nxt = ST_IDLE;
          item_nxt  = 1'b0;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (cfg_wr) begin
      state_nxt = ST_SEED;
    end
  end

  always_comb begin
    cmd         = '0;
    cmd.mul_sel = MUL_SW;
    in_ready    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.start = in_valid;
      end
      ST_SEED: cmd.seed = 1'b1;
      ST_P0: begin
        cmd.word_ld = 1'b1;
        cmd.mul_sel = MUL_LL;
      end
      ST_P1: begin
        cmd.acc_ld  = 1'b1;
        cmd.mul_sel = MUL_HL;
      end
      ST_P2: begin
        cmd.acc_add = 1'b1;
        cmd.mul_sel = MUL_LH;
      end
      ST_P3: begin
        cmd.acc_add = 1'b1;
        cmd.mul_sel = MUL_SW;
      end
      ST_ADV: begin
        cmd.adv  = 1'b1;
        cmd.eval = item_r;
      end
      ST_OUT: cmd.out_ld = status.out_free;
      default: cmd = '0;
    endcase
  end

  `BRI_ASSERT_NEXT(a_cfg_reseeds, cfg_wr, state_r == ST_SEED)
  `BRI_ASSERT_NEXT(a_accept_draws, cmd.start && !cfg_wr, state_r == ST_P0 && item_r)
  `BRI_ASSERT_NEXT(a_p3_advances, state_r == ST_P3 && !cfg_wr, state_r == ST_ADV)

endmodule

// ===== sv/bri_dp.sv =====
// Generator state, shared 32x32 multiplier, carry extension and result register.
`include "bounded_random_integer_defines.svh"

module bri_dp #(
  parameter int unsigned MAX_EXTRA_WORDS = 10
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  bri_pkg::bri_cmd_t    cmd,
  input  logic [63:0]          seed_value,
  input  logic [63:0]          stream_select,
  input  logic [31:0]          in_bound,
  input  logic                 out_ready,
  output bri_pkg::bri_status_t status,
  output logic                 out_valid,
  output logic [31:0]          out_value,
  output logic [3:0]           out_words_drawn
);
  import bri_pkg::*;

  localparam int unsigned EXTRA_W = $clog2(MAX_EXTRA_WORDS + 2);
  localparam logic [EXTRA_W-1:0] EXTRA_MAX = EXTRA_W'(MAX_EXTRA_WORDS);

  logic [63:0] state_r, inc_r, acc_r, mul_r;
  logic [31:0] word_r, s_r, frac_r, ipart_r, res_r;
  logic [3:0]  used_r;
  logic [EXTRA_W-1:0] extra_r;
  logic        first_r;
  logic        out_valid_r;
  logic [31:0] out_value_r;
  logic [3:0]  out_words_r;

  logic [31:0] mul_a, mul_b;
  logic [63:0] inc_seed;
  logic [31:0] prod_hi, prod_lo, neg_s;
  logic [32:0] sum;
  logic [EXTRA_W-1:0] extra_inc;
  logic [3:0]  used_inc;
  logic        carry, all_ones, done_now;

  always_comb begin
    case (cmd.mul_sel)
      MUL_LL: begin
        mul_a = state_r[31:0];
        mul_b = LCG_MULT_LO;
      end
      MUL_HL: begin
        mul_a = state_r[63:32];
        mul_b = LCG_MULT_LO;
      end
      MUL_LH: begin
        mul_a = state_r[31:0];
        mul_b = LCG_MULT_HI;
      end
      default: begin
        mul_a = s_r;
        mul_b = word_r;
      end
    endcase
  end

  assign inc_seed  = {stream_select[62:0], 1'b1};
  assign prod_hi   = mul_r[63:32];
  assign prod_lo   = mul_r[31:0];
  assign neg_s     = 32'd0 - s_r;
  assign sum       = {1'b0, frac_r} + {1'b0, prod_hi};
  assign carry     = sum[32];
  assign all_ones  = (sum[31:0] == 32'hFFFF_FFFF);
  assign extra_inc = extra_r + 1'b1;
  assign used_inc  = (used_r == 4'hF) ? used_r : used_r + 4'd1;

  always_comb begin
    if (first_r) begin
      done_now = (prod_lo <= neg_s) || (MAX_EXTRA_WORDS == 0);
    end else begin
      done_now = carry || !all_ones || (extra_inc == EXTRA_MAX);
    end
  end

  assign status.done_now = done_now;
  assign status.out_free = !out_valid_r || out_ready;

  // generator and multiplier pipeline
  always_ff @(posedge clk) begin
    mul_r <= mul_a * mul_b;
    if (cmd.seed) begin
      inc_r   <= inc_seed;
      state_r <= inc_seed + seed_value;
    end else if (cmd.adv) begin
      state_r <= acc_r + inc_r;
    end
    if (cmd.word_ld) begin
      word_r <= pcg_word(state_r);
    end
    if (cmd.acc_ld) begin
      acc_r <= mul_r;
    end else if (cmd.acc_add) begin
      acc_r[63:32] <= acc_r[63:32] + prod_lo;
    end
    if (cmd.start) begin
      s_r <= in_bound;
    end
    if (cmd.eval) begin
      frac_r <= prod_lo;
      if (first_r) begin
        ipart_r <= prod_hi;
        res_r   <= prod_hi;
        used_r  <= 4'd1;
      end else begin
        used_r <= used_inc;
        if (carry) begin
          res_r <= ipart_r + 32'd1;
        end
      end
    end
    if (cmd.out_ld) begin
      out_value_r <= res_r;
      out_words_r <= used_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r     <= 1'b0;
      extra_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.start) begin
        first_r <= 1'b1;
        extra_r <= '0;
      end else if (cmd.eval) begin
        first_r <= 1'b0;
        if (!first_r) begin
          extra_r <= extra_inc;
        end
      end
      if (cmd.out_ld) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_value       = out_value_r;
  assign out_words_drawn = out_words_r;

  `BRI_ASSERT_SAME(a_words_nonzero, out_valid_r, out_words_r != 4'd0)
  `BRI_ASSERT_NEXT(a_extra_counts, cmd.eval && !first_r && used_r != 4'hF, used_r >= 4'd2)
  `BRI_ASSERT_SAME(a_no_load_when_full, cmd.out_ld, !out_valid_r || out_ready)

endmodule

// ===== sv/bounded_random_integer.sv =====
// Top level of the bounded random integer block: register port, sequencer and datapath.
//
// Returns a random integer in [0, bound) from a built-in PCG32 XSH-RR generator,
// extending the fraction with extra words while a carry into the integer part is still
// possible. For each generator word the sequencer steps through P0, P1, P2, P3 and ADV: one
// shared 32x32 multiplier forms the three partial products of the 64-bit LCG step and the
// bound-times-word product in turn, and the state update and carry check share ADV. An item
// runs these steps once per word drawn before its result loads, and the next item is only
// accepted once the block is back in idle; an item draws 1 to 1 + MAX_EXTRA_WORDS words,
// most often 1. A result waits in an output register while the next item is accepted; a
// result that cannot load because the previous one is still held stalls the block until it
// leaves. After reset and after every register write the generator reseeds, during which
// no item is accepted. Registers are 64 bits at byte address 0 (seed) and 8 (stream).
module bounded_random_integer #(
  parameter int unsigned MAX_EXTRA_WORDS = 10
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [31:0]                in_bound,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [31:0]                out_value,
  output logic [3:0]                 out_words_drawn,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bri_pkg::ADDR_W-1:0] paddr,
  input  logic [63:0]                pwdata,
  output logic [63:0]                prdata,
  output logic                       pready
);
  import bri_pkg::*;

  logic [63:0] seed_r, stream_r;
  logic        cfg_wr;
  bri_cmd_t    cmd;
  bri_status_t status;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r   <= SEED_RST;
      stream_r <= STREAM_RST;
    end else if (cfg_wr) begin
      if (paddr[3] == REG_STREAM) begin
        stream_r <= pwdata;
      end else begin
        seed_r <= pwdata;
      end
    end
  end

  assign prdata = (paddr[3] == REG_SEED) ? seed_r : stream_r;

  bri_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .cfg_wr   (cfg_wr),
    .status   (status),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  bri_dp #(
    .MAX_EXTRA_WORDS (MAX_EXTRA_WORDS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .seed_value      (seed_r),
    .stream_select   (stream_r),
    .in_bound        (in_bound),
    .out_ready       (out_ready),
    .status          (status),
    .out_valid       (out_valid),
    .out_value       (out_value),
    .out_words_drawn (out_words_drawn)
  );

endmodule

// ===== test/bounded_random_integer_test.sv =====
// Testbench for bounded_random_integer: random and edge-case bounds checked against a PCG32 bounded-draw predictor.
`timescale 1ns / 100ps

module bounded_random_integer_test;

  localparam logic [63:0] PCG_MULT        = 64'h5851_F42D_4C95_7F2D;
  localparam logic [63:0] SEED_AT_RESET   = 64'h0000_0000_DEAD_BEEF;
  localparam logic [63:0] STREAM_AT_RESET = 64'h0000_0BAD_CAFE_FACE;
  localparam int          EXTRA_WORDS     = 10;
  localparam int          SEED_INDEX      = 0;
  localparam int          STREAM_INDEX    = 1;
  localparam int          STALL_LIMIT     = 4000;
  localparam int          SETTLE_CYCLES   = 60;

  typedef struct packed {
    logic [31:0] value;
    logic [3:0]  words;
  } draw_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [31:0] in_bound;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_value;
  logic [3:0]  out_words_drawn;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [bri_pkg::ADDR_W-1:0] paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  logic [63:0] seed_reg;
  logic [63:0] stream_reg;
  logic [63:0] gen_state;
  logic [63:0] gen_inc;
  draw_t       pending_draws[$];
  int          mismatch_count = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          stall_cycles = 0;

  bounded_random_integer dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_bound(in_bound),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_value(out_value),
    .out_words_drawn(out_words_drawn),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #2 clk = ~clk;

  function automatic logic [31:0] next_pcg_word();
    logic [63:0] old;
    logic [31:0] mixed;
    logic [4:0]  rot;
    logic [4:0]  back;
    old = gen_state;
    gen_state = old * PCG_MULT + gen_inc;
    mixed = 32'(((old >> 18) ^ old) >> 27);
    rot = old[63:59];
    back = 5'd0 - rot;
    return (mixed >> rot) | (mixed << back);
  endfunction

  function automatic void reseed_generator();
    gen_state = 64'd0;
    gen_inc = {stream_reg[62:0], 1'b1};
    gen_state = gen_state * PCG_MULT + gen_inc;
    gen_state = gen_state + seed_reg;
    gen_state = gen_state * PCG_MULT + gen_inc;
  endfunction

  function automatic draw_t predict_draw(input logic [31:0] s);
    logic [63:0] prod;
    logic [31:0] ipart;
    logic [31:0] frac;
    logic [32:0] sum;
    int          used;
    bit          settled;
    draw_t       d;
    prod = 64'(s) * 64'(next_pcg_word());
    ipart = prod[63:32];
    frac = prod[31:0];
    d.value = ipart;
    used = 1;
    settled = 1'b0;
    if (frac > 32'd0 - s) begin
      for (int k = 0; k < EXTRA_WORDS && !settled; k++) begin
        prod = 64'(s) * 64'(next_pcg_word());
        used++;
        sum = {1'b0, frac} + {1'b0, prod[63:32]};
        frac = sum[31:0];
        if (sum[32]) begin
          d.value = ipart + 32'd1;
          settled = 1'b1;
        end else if (frac != 32'hFFFF_FFFF) begin
          settled = 1'b1;
        end else begin
          frac = prod[31:0];
        end
      end
    end
    d.words = (used > 15) ? 4'd15 : 4'(used);
    return d;
  endfunction

  function automatic void note_mismatch(input string what, input logic [63:0] want,
                                        input logic [63:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%s: expected %0h, got %0h", what, want, got);
  endfunction

  function automatic logic [31:0] pick_bound();
    int sel;
    sel = $urandom_range(99);
    if (sel < 40) return $urandom;
    if (sel < 70) return {1'b1, 31'($urandom)};
    if (sel < 85) return 32'($urandom_range(255));
    if (sel < 95) return 32'hFFFF_FFFF - 32'($urandom_range(15));
    return 32'($urandom_range(1));
  endfunction

  task automatic send_bound(input logic [31:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_bound <= b;
    do @(posedge clk); while (!in_ready);
    pending_draws.push_back(predict_draw(b));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_draws.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_register(input int index, input logic [63:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= bri_pkg::ADDR_W'(index * 8);
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== data) note_mismatch("register readback", data, prdata);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if (index == SEED_INDEX) seed_reg = data;
    else stream_reg = data;
    reseed_generator();
  endtask

  task automatic test_reset_seed();
    logic [31:0] edge_bounds[16];
    edge_bounds = '{32'h0, 32'h1, 32'h2, 32'h3, 32'hA, 32'h64, 32'hFFFF_FFFF,
                    32'hFFFF_FFFE, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0001,
                    32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_0000, 32'h0000_FFFF, 32'h0};
    send_idle_pct = 38;
    recv_idle_pct = 57;
    foreach (edge_bounds[i]) send_bound(edge_bounds[i]);
    repeat (4) send_bound(32'hFFFF_FFFF);
    wait_drained();
  endtask

  task automatic test_register_extremes(input logic [63:0] data);
    write_register(SEED_INDEX, data);
    write_register(STREAM_INDEX, data);
    repeat (20) send_bound(pick_bound());
    wait_drained();
  endtask

  task automatic test_random_bounds(input int count, input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    write_register(SEED_INDEX, {$urandom, $urandom});
    write_register(STREAM_INDEX, {$urandom, $urandom});
    repeat (count) send_bound(pick_bound());
    wait_drained();
  endtask

  task automatic test_drain_pause();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (5) begin
      repeat (6) send_bound(pick_bound());
      wait_drained();
    end
    write_register(STREAM_INDEX, {$urandom, $urandom});
    repeat (10) send_bound(pick_bound());
    wait_drained();
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    draw_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_draws.size() == 0) begin
        note_mismatch("unexpected result value", 64'd0, 64'(out_value));
      end else begin
        want = pending_draws.pop_front();
        if (out_value !== want.value)
          note_mismatch("value", 64'(want.value), 64'(out_value));
        if (out_words_drawn !== want.words)
          note_mismatch("words_drawn", 64'(want.words), 64'(out_words_drawn));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_bound = 32'd0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = 64'd0;
    seed_reg = SEED_AT_RESET;
    stream_reg = STREAM_AT_RESET;
    reseed_generator();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_seed();
    test_register_extremes(64'd0);
    test_register_extremes(64'hFFFF_FFFF_FFFF_FFFF);
    test_random_bounds(330, 38, 57);
    test_random_bounds(330, 57, 38);
    test_random_bounds(330, 0, 0);
    test_drain_pause();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_draws.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
